@@ rtl/hsv_pkg.sv @@
// hsv_pkg: shared widths, constants, sector codes and stage word types
// for the HSV to RGB converter. No dependencies.
`timescale 1ns / 1ps

package hsv_pkg;

	// Field widths
	localparam int HUE_W     = 10;
	localparam int LEVEL_W   = 8;
	localparam int HUE_RED_W = 9;   // hue after the modulo-360 fold
	localparam int FRAC_W    = 6;   // hue inside one sector, 0..59
	localparam int BLEND_W   = 14;  // 15300 - s*h fits in 14 bits
	localparam int PROD_P_W  = 16;  // v*(255-s)
	localparam int PROD_W    = 22;  // v*(15300-s*h)
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	// Arithmetic constants
	localparam int HUE_FULL   = 360;
	localparam int SECTOR_DEG = 60;
	localparam int LEVEL_MAX  = 255;
	localparam int BLEND_DEN  = 15300;  // 255 * 60

	// Reciprocals: floor(x/C) is (x*R)>>K or one less
	localparam int RECIP_P       = 257;
	localparam int RECIP_P_SHIFT = 16;
	localparam int RECIP_Q       = 70179;  // floor(2^30 / 15300)
	localparam int RECIP_Q_SHIFT = 30;

	// 60-degree sectors, named by the color at their start
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// Word from the sector stages to the level stages
	typedef struct packed {
		sector_t             sector;
		logic [FRAC_W-1:0]   frac;
		logic [LEVEL_W-1:0]  sat;
		logic [LEVEL_W-1:0]  val;
	} sec_word_t;

	// Word from the level stages to the divide stages
	typedef struct packed {
		sector_t              sector;
		logic [LEVEL_W-1:0]   val;
		logic [PROD_P_W-1:0]  prod_p;
		logic [PROD_W-1:0]    prod_q;
		logic [PROD_W-1:0]    prod_t;
	} lvl_word_t;

endpackage

@@ rtl/hsv_sector.sv @@
// hsv_sector: two pipeline stages that fold the hue modulo 360, then pick
// the 60-degree sector and the hue offset inside it. Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_sector import hsv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [HUE_W-1:0]    hue,
	input  logic [LEVEL_W-1:0]  sat,
	input  logic [LEVEL_W-1:0]  val,
	output logic                out_valid,
	input  logic                out_ready,
	output sec_word_t           out_word
);

	logic                  vld_s1, vld_s2;
	logic                  ready_s1, ready_s2;
	logic [HUE_RED_W-1:0]  hue_s1;
	logic [LEVEL_W-1:0]    sat_s1, val_s1;
	logic [HUE_RED_W-1:0]  hue_red;
	sector_t               sector_nx;
	logic [HUE_RED_W-1:0]  base_nx;
	sec_word_t             word_s2;

	// A stage takes a new word when empty or when its word moves on
	assign ready_s2 = !vld_s2 || out_ready;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Fold hue into 0..359
	always_comb begin
		priority if (hue >= HUE_W'(2 * HUE_FULL)) begin
			hue_red = HUE_RED_W'(hue - HUE_W'(2 * HUE_FULL));
		end else if (hue >= HUE_W'(HUE_FULL)) begin
			hue_red = HUE_RED_W'(hue - HUE_W'(HUE_FULL));
		end else begin
			hue_red = HUE_RED_W'(hue);
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			hue_s1 <= hue_red;
			sat_s1 <= sat;
			val_s1 <= val;
		end
	end

	// Pick the sector and its start angle
	always_comb begin
		priority if (hue_s1 >= HUE_RED_W'(5 * SECTOR_DEG)) begin
			sector_nx = SEC_MAGENTA;
			base_nx   = HUE_RED_W'(5 * SECTOR_DEG);
		end else if (hue_s1 >= HUE_RED_W'(4 * SECTOR_DEG)) begin
			sector_nx = SEC_BLUE;
			base_nx   = HUE_RED_W'(4 * SECTOR_DEG);
		end else if (hue_s1 >= HUE_RED_W'(3 * SECTOR_DEG)) begin
			sector_nx = SEC_CYAN;
			base_nx   = HUE_RED_W'(3 * SECTOR_DEG);
		end else if (hue_s1 >= HUE_RED_W'(2 * SECTOR_DEG)) begin
			sector_nx = SEC_GREEN;
			base_nx   = HUE_RED_W'(2 * SECTOR_DEG);
		end else if (hue_s1 >= HUE_RED_W'(SECTOR_DEG)) begin
			sector_nx = SEC_YELLOW;
			base_nx   = HUE_RED_W'(SECTOR_DEG);
		end else begin
			sector_nx = SEC_RED;
			base_nx   = '0;
		end
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ready_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && vld_s1) begin
			word_s2.sector <= sector_nx;
			word_s2.frac   <= FRAC_W'(hue_s1 - base_nx);
			word_s2.sat    <= sat_s1;
			word_s2.val    <= val_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_word  = word_s2;

endmodule

@@ rtl/hsv_level.sv @@
// hsv_level: two pipeline stages that form the blend numerators
// v*(255-s), v*(15300-s*h) and v*(15300-s*(60-h)). Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_level import hsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sec_word_t  in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output lvl_word_t  out_word
);

	logic                 vld_s3, vld_s4;
	logic                 ready_s3, ready_s4;
	sector_t              sector_s3;
	logic [LEVEL_W-1:0]   val_s3;
	logic [LEVEL_W-1:0]   diff_p_s3;
	logic [BLEND_W-1:0]   blend_q_s3, blend_t_s3;
	logic [FRAC_W:0]      frac_left;
	logic [BLEND_W-1:0]   sh_q, sh_t;
	lvl_word_t            word_s4;

	assign ready_s4 = !vld_s4 || out_ready;
	assign ready_s3 = !vld_s3 || ready_s4;
	assign in_ready = ready_s3;

	// Saturation weighted by the hue offset and by its complement
	assign frac_left = (FRAC_W + 1)'(SECTOR_DEG) - {1'b0, in_word.frac};
	assign sh_q      = BLEND_W'(in_word.sat) * BLEND_W'(in_word.frac);
	assign sh_t      = BLEND_W'(in_word.sat) * BLEND_W'(frac_left);

	// Stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ready_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			sector_s3  <= in_word.sector;
			val_s3     <= in_word.val;
			diff_p_s3  <= LEVEL_W'(LEVEL_MAX) - in_word.sat;
			blend_q_s3 <= BLEND_W'(BLEND_DEN) - sh_q;
			blend_t_s3 <= BLEND_W'(BLEND_DEN) - sh_t;
		end
	end

	// Stage 4 register: scale by value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ready_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && vld_s3) begin
			word_s4.sector <= sector_s3;
			word_s4.val    <= val_s3;
			word_s4.prod_p <= PROD_P_W'(val_s3) * PROD_P_W'(diff_p_s3);
			word_s4.prod_q <= PROD_W'(val_s3) * PROD_W'(blend_q_s3);
			word_s4.prod_t <= PROD_W'(val_s3) * PROD_W'(blend_t_s3);
		end
	end

	assign out_valid = vld_s4;
	assign out_word  = word_s4;

endmodule

@@ rtl/hsv_div.sv @@
// hsv_div: two pipeline stages that divide the numerators by 255 and 15300
// through reciprocal multiply and one correction, then route the channels.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_div import hsv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lvl_word_t           in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LEVEL_W-1:0]  red,
	output logic [LEVEL_W-1:0]  green,
	output logic [LEVEL_W-1:0]  blue
);

	localparam int MUL_P_W = PROD_P_W + 9;
	localparam int MUL_Q_W = PROD_W + 17;

	logic                vld_s5, vld_s6;
	logic                ready_s5, ready_s6;
	lvl_word_t           word_s5;
	logic [LEVEL_W-1:0]  est_p_s5, est_q_s5, est_t_s5;
	logic [MUL_P_W-1:0]  mul_p;
	logic [MUL_Q_W-1:0]  mul_q, mul_t;
	logic [PROD_P_W-1:0] rem_p;
	logic [PROD_W-1:0]   rem_q, rem_t;
	logic [LEVEL_W-1:0]  lvl_p, lvl_q, lvl_t;
	logic [LEVEL_W-1:0]  red_nx, green_nx, blue_nx;
	logic [LEVEL_W-1:0]  red_s6, green_s6, blue_s6;

	assign ready_s6 = !vld_s6 || out_ready;
	assign ready_s5 = !vld_s5 || ready_s6;
	assign in_ready = ready_s5;

	// Quotient estimates, at most one low
	assign mul_p = MUL_P_W'(in_word.prod_p) * MUL_P_W'(RECIP_P);
	assign mul_q = MUL_Q_W'(in_word.prod_q) * MUL_Q_W'(RECIP_Q);
	assign mul_t = MUL_Q_W'(in_word.prod_t) * MUL_Q_W'(RECIP_Q);

	// Stage 5 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (ready_s5) begin
			vld_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && in_valid) begin
			word_s5  <= in_word;
			est_p_s5 <= mul_p[RECIP_P_SHIFT +: LEVEL_W];
			est_q_s5 <= mul_q[RECIP_Q_SHIFT +: LEVEL_W];
			est_t_s5 <= mul_t[RECIP_Q_SHIFT +: LEVEL_W];
		end
	end

	// Correct each estimate by one where the remainder reaches the divisor
	assign rem_p = word_s5.prod_p - PROD_P_W'(est_p_s5) * PROD_P_W'(LEVEL_MAX);
	assign rem_q = word_s5.prod_q - PROD_W'(est_q_s5) * PROD_W'(BLEND_DEN);
	assign rem_t = word_s5.prod_t - PROD_W'(est_t_s5) * PROD_W'(BLEND_DEN);

	assign lvl_p = (rem_p >= PROD_P_W'(LEVEL_MAX)) ? est_p_s5 + 8'd1 : est_p_s5;
	assign lvl_q = (rem_q >= PROD_W'(BLEND_DEN)) ? est_q_s5 + 8'd1 : est_q_s5;
	assign lvl_t = (rem_t >= PROD_W'(BLEND_DEN)) ? est_t_s5 + 8'd1 : est_t_s5;

	// Route value and blend levels by sector
	always_comb begin
		unique case (word_s5.sector)
			SEC_RED: begin
				red_nx = word_s5.val; green_nx = lvl_t; blue_nx = lvl_p;
			end
			SEC_YELLOW: begin
				red_nx = lvl_q; green_nx = word_s5.val; blue_nx = lvl_p;
			end
			SEC_GREEN: begin
				red_nx = lvl_p; green_nx = word_s5.val; blue_nx = lvl_t;
			end
			SEC_CYAN: begin
				red_nx = lvl_p; green_nx = lvl_q; blue_nx = word_s5.val;
			end
			SEC_BLUE: begin
				red_nx = lvl_t; green_nx = lvl_p; blue_nx = word_s5.val;
			end
			default: begin
				red_nx = word_s5.val; green_nx = lvl_p; blue_nx = lvl_q;
			end
		endcase
	end

	// Stage 6 register: output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (ready_s6) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6 && vld_s5) begin
			red_s6   <= red_nx;
			green_s6 <= green_nx;
			blue_s6  <= blue_nx;
		end
	end

	assign out_valid = vld_s6;
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// Pipeline: six register stages, s1 to s6, from the input register to the
// output register. Throughput: one word per clock while m_tready is high, set
// by the fully pipelined datapath; each stage takes a new word while empty, so
// bubbles close up under a stall.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// Depends on hsv_pkg, hsv_sector, hsv_level and hsv_div.
`timescale 1ns / 1ps

module hsv_to_rgb_converter import hsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: [9:0] hue_deg, [17:10] sat_level, [25:18] val_level, [31:26] zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: [7:0] red_out, [15:8] green_out, [23:16] blue_out
	output logic [M_TDATA_W-1:0]  m_tdata
);

	logic                sec_valid, sec_ready;
	sec_word_t           sec_word;
	logic                lvl_valid, lvl_ready;
	lvl_word_t           lvl_word;
	logic [LEVEL_W-1:0]  red_out, green_out, blue_out;

	// Hue fold and sector select
	hsv_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.hue       (s_tdata[HUE_W-1:0]),
		.sat       (s_tdata[HUE_W +: LEVEL_W]),
		.val       (s_tdata[HUE_W + LEVEL_W +: LEVEL_W]),
		.out_valid (sec_valid),
		.out_ready (sec_ready),
		.out_word  (sec_word)
	);

	// Blend numerators
	hsv_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sec_valid),
		.in_ready  (sec_ready),
		.in_word   (sec_word),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.out_word  (lvl_word)
	);

	// Constant division and channel routing
	hsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lvl_valid),
		.in_ready  (lvl_ready),
		.in_word   (lvl_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red       (red_out),
		.green     (green_out),
		.blue      (blue_out)
	);

	assign m_tdata = {blue_out, green_out, red_out};

endmodule

@@ rtl/hsv_chk.sv @@
// hsv_chk: port-level checks on the HSV to RGB converter, attached to the
// top level by a bind. Depends on hsv_pkg and hsv_to_rgb_converter.
`timescale 1ns / 1ps

module hsv_chk import hsv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata
);

	logic in_acc;
	logic [LEVEL_W-1:0] in_sat, in_val;

	assign in_acc = s_tvalid && s_tready;
	assign in_sat = s_tdata[HUE_W +: LEVEL_W];
	assign in_val = s_tdata[HUE_W + LEVEL_W +: LEVEL_W];

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// An open output side must never stall the input
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// With no stall, an accepted word shows up after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("result missing after pipeline latency");

	// Drop of saturation gives grey: all channels equal value
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_sat == '0) && (in_val == 8'd200)
		##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid && (m_tdata == {3{8'd200}}))
		else $error("grey pixel not carried through");

	// Zero value gives black whatever hue and saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_val == '0)
		##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid && (m_tdata == '0))
		else $error("black pixel not carried through");

endmodule

bind hsv_to_rgb_converter hsv_chk u_hsv_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ bench/hsv_to_rgb_converter_tb.sv @@
// hsv_to_rgb_converter_tb: self-checking bench for the HSV to RGB converter.
// Uses hsv_pkg. Drives hue/saturation/value words through the stream ports with
// random gaps and stalls; checks each output word against a typed or modelled color.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
	import hsv_pkg::*;

	localparam int N_RANDOM    = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER  = 900;   // words sent before the long output hold
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 16;
	localparam int MAX_REPORTS = 10;

	// Packed so that red lands in the low byte, as on m_tdata
	typedef struct packed {
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
	} rgb_t;

	// One row of directed stimulus; a typed color is used when fixed is set
	typedef struct {
		logic [HUE_W-1:0]   hue;
		logic [LEVEL_W-1:0] sat;
		logic [LEVEL_W-1:0] val;
		bit                 fixed;
		rgb_t               color;
	} hsv_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	rgb_t        pending_rgb[$];
	int unsigned words_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	hsv_to_rgb_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Integer color model: fold the hue, pick the sector, blend exactly
	function automatic rgb_t hsv_to_rgb(logic [HUE_W-1:0] hue, logic [LEVEL_W-1:0] sat,
			logic [LEVEL_W-1:0] val);
		int unsigned hfold, frac, s, v, lvl_p, lvl_q, lvl_t;
		sector_t     sec;
		rgb_t        c;
		hfold = int'(hue) % HUE_FULL;
		frac  = hfold % SECTOR_DEG;
		sec   = sector_t'(hfold / SECTOR_DEG);
		s     = 32'(sat);
		v     = 32'(val);
		lvl_p = (v * (LEVEL_MAX - s)) / LEVEL_MAX;
		lvl_q = (v * (BLEND_DEN - s * frac)) / BLEND_DEN;
		lvl_t = (v * (BLEND_DEN - s * (SECTOR_DEG - frac))) / BLEND_DEN;
		case (sec)
			SEC_RED: begin
				c.red = LEVEL_W'(v); c.green = LEVEL_W'(lvl_t); c.blue = LEVEL_W'(lvl_p);
			end
			SEC_YELLOW: begin
				c.red = LEVEL_W'(lvl_q); c.green = LEVEL_W'(v); c.blue = LEVEL_W'(lvl_p);
			end
			SEC_GREEN: begin
				c.red = LEVEL_W'(lvl_p); c.green = LEVEL_W'(v); c.blue = LEVEL_W'(lvl_t);
			end
			SEC_CYAN: begin
				c.red = LEVEL_W'(lvl_p); c.green = LEVEL_W'(lvl_q); c.blue = LEVEL_W'(v);
			end
			SEC_BLUE: begin
				c.red = LEVEL_W'(lvl_t); c.green = LEVEL_W'(lvl_p); c.blue = LEVEL_W'(v);
			end
			default: begin
				c.red = LEVEL_W'(v); c.green = LEVEL_W'(lvl_p); c.blue = LEVEL_W'(lvl_q);
			end
		endcase
		return c;
	endfunction

	// Sender burst state
	int unsigned burst_left = 0;

	// Offer one word, hold it until taken, then queue its color and maybe idle
	task automatic send_hsv(logic [HUE_W-1:0] hue, logic [LEVEL_W-1:0] sat,
			logic [LEVEL_W-1:0] val, rgb_t color);
		int unsigned gap;
		s_tdata  = {{(S_TDATA_W - HUE_W - 2 * LEVEL_W){1'b0}}, val, sat, hue};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_rgb.push_back(color);
		words_sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Pick a level, leaning on the extremes
	function automatic logic [LEVEL_W-1:0] pick_level();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return '1;
		return LEVEL_W'($urandom_range(0, 255));
	endfunction

	// Pick a hue: mostly anywhere, often on a sector edge, sometimes wrapped
	function automatic logic [HUE_W-1:0] pick_hue();
		int unsigned sel, h;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			h = $urandom_range(0, 5) * SECTOR_DEG + (($urandom_range(0, 1) == 1) ? 59 : 0);
			h = h + $urandom_range(0, 1) * HUE_FULL;
			return HUE_W'(h);
		end
		return HUE_W'($urandom_range(0, 1023));
	endfunction

	// Directed rows: corners, every sector start and end, hue wrap
	hsv_row_t dir_rows[] = '{
		'{10'd0,    8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{10'd0,    8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{10'd60,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{10'd120,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{10'd180,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{10'd240,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{10'd300,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{10'd360,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{10'd720,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{10'd200,  8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{10'd1000, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
		'{10'd45,   8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{10'd1023, 8'd255, 8'd255, 1'b0, '0},
		'{10'd59,   8'd255, 8'd255, 1'b0, '0},
		'{10'd119,  8'd255, 8'd255, 1'b0, '0},
		'{10'd179,  8'd200, 8'd255, 1'b0, '0},
		'{10'd239,  8'd255, 8'd180, 1'b0, '0},
		'{10'd299,  8'd1,   8'd255, 1'b0, '0},
		'{10'd359,  8'd254, 8'd254, 1'b0, '0},
		'{10'd30,   8'd128, 8'd200, 1'b0, '0},
		'{10'd90,   8'd77,  8'd33,  1'b0, '0},
		'{10'd719,  8'd170, 8'd85,  1'b0, '0},
		'{10'd512,  8'd85,  8'd170, 1'b0, '0}
	};

	// Reset, walk the table, random words, drain, report
	initial begin
		hsv_row_t                    row;
		logic [HUE_W-1:0]            hue;
		logic [LEVEL_W-1:0]          sat, val;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_hsv(row.hue, row.sat, row.val,
				row.fixed ? row.color : hsv_to_rgb(row.hue, row.sat, row.val));
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			hue = pick_hue();
			sat = pick_level();
			val = pick_level();
			send_hsv(hue, sat, val, hsv_to_rgb(hue, sat, val));
		end
		s_tvalid = 1'b0;

		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Output side: stall in changing patterns, plus one long hold mid-run
	initial begin
		int unsigned mode, mode_left, hold_left, phase;
		bit          hold_done;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		phase     = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else if (!hold_done && words_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready  = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(64, 256);
				end
				mode_left--;
				phase++;
				case (mode)
					0:       m_tready = 1'b1;
					1:       m_tready = ($urandom_range(0, 3) != 0);
					2:       m_tready = ($urandom_range(0, 3) == 0);
					default: m_tready = (phase % 5) < 2;
				endcase
			end
		end
	end

	// Check each taken output word against the oldest queued color
	always @(posedge clk) begin
		rgb_t want, got;
		bit   bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_rgb.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected word r=%0d g=%0d b=%0d",
						$realtime, got.red, got.green, got.blue);
			end else begin
				want = pending_rgb.pop_front();
				bad  = (got.red !== want.red) || (got.green !== want.green) ||
					(got.blue !== want.blue);
				if (bad) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("[%0t] color mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							$realtime, want.red, want.green, want.blue,
							got.red, got.green, got.blue);
				end
			end
		end
	end

	// Stop a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[%0t] timeout with %0d colors pending", $realtime, pending_rgb.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ hsv_to_rgb_converter.f @@
rtl/hsv_pkg.sv
rtl/hsv_sector.sv
rtl/hsv_level.sv
rtl/hsv_div.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsv_chk.sv
bench/hsv_to_rgb_converter_tb.sv
